@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sadpcm_pkg.sv @@
// ----------------------------------------------------------------------------
// sadpcm_pkg
// Types and constants of the stereo ADPCM stream decoder.
// ----------------------------------------------------------------------------
package sadpcm_pkg;

  // Block layout
  localparam int BLOCK_BYTES     = 32;
  localparam int PAIRS_PER_BLOCK = 28;
  localparam int POS_W           = $clog2(BLOCK_BYTES);
  localparam int START_I         = ((BLOCK_BYTES - PAIRS_PER_BLOCK) < 2) ? 2 :
                                   (BLOCK_BYTES - PAIRS_PER_BLOCK);

  localparam logic [POS_W-1:0] POS_LEFT_HDR  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_RIGHT_HDR = POS_W'(1);
  localparam logic [POS_W-1:0] POS_START     = POS_W'(START_I);
  localparam logic [POS_W-1:0] POS_LAST      = POS_W'(BLOCK_BYTES - 1);

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int CODE_W   = 4;
  localparam int HIST_W   = 23;
  localparam int PRED_W   = 22;
  localparam int SAMPLE_W = 16;
  localparam int MAC_W    = 32;
  localparam int FRAC_W   = 6;
  localparam int SCALE_W  = 12;

  // Commands
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Predictor selects (all other codes predict zero)
  localparam logic [3:0] PRED_FIX1 = 4'd1;
  localparam logic [3:0] PRED_FIX2 = 4'd2;
  localparam logic [3:0] PRED_FIX3 = 4'd3;

  // Predictor coefficients
  localparam logic signed [MAC_W-1:0] COEF1_A = 32'sh3c;
  localparam logic signed [MAC_W-1:0] COEF2_A = 32'sh73;
  localparam logic signed [MAC_W-1:0] COEF2_B = 32'sh34;
  localparam logic signed [MAC_W-1:0] COEF3_A = 32'sh62;
  localparam logic signed [MAC_W-1:0] COEF3_B = 32'sh37;
  localparam logic signed [MAC_W-1:0] PRED_ROUND = 32'sh20;

  typedef logic signed [HIST_W-1:0]   hist_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [3:0] pred;
    logic [3:0] shift;
  } head_t;

endpackage

@@ rtl/core/sadpcm_in_if.sv @@
// ----------------------------------------------------------------------------
// sadpcm_in_if
// Input channel: one command or block byte per item.
// ----------------------------------------------------------------------------
interface sadpcm_in_if;
  import sadpcm_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

@@ rtl/core/sadpcm_out_if.sv @@
// ----------------------------------------------------------------------------
// sadpcm_out_if
// Output channel: one decoded stereo pair per item.
// ----------------------------------------------------------------------------
interface sadpcm_out_if;
  import sadpcm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t left_sample;
  sample_t right_sample;
  logic    last_in_block;

  modport source (output valid, output left_sample, output right_sample,
                  output last_in_block, input ready);
  modport sink   (input valid, input left_sample, input right_sample,
                  input last_in_block, output ready);
endinterface

@@ rtl/core/sadpcm_chan.sv @@
// ----------------------------------------------------------------------------
// sadpcm_chan
// One channel of the decoder: prediction, nibble scaling, new history and
// saturated output sample. Purely combinational.
// ----------------------------------------------------------------------------
module sadpcm_chan (
  input  logic [sadpcm_pkg::CODE_W-1:0] code_i,
  input  sadpcm_pkg::head_t             head_i,
  input  sadpcm_pkg::hist_t             prev1_i,
  input  sadpcm_pkg::hist_t             prev2_i,
  output sadpcm_pkg::hist_t             hist_o,
  output sadpcm_pkg::sample_t           sample_o
);
  import sadpcm_pkg::*;

  localparam int RND_W = MAC_W - FRAC_W;
  localparam int SMP_W = HIST_W - FRAC_W;

  logic signed [MAC_W-1:0]            coef_a, coef_b;
  logic signed [MAC_W-1:0]            p1_x, p2_x, mac, mac_rnd;
  logic signed [RND_W-1:0]            rnd;
  logic signed [PRED_W-1:0]           pred;
  logic signed [CODE_W+SCALE_W-1:0]   scaled, shifted;
  logic signed [PRED_W-1:0]           delta;
  logic signed [SMP_W-1:0]            smp_wide;

  always_comb begin
    unique case (head_i.pred)
      PRED_FIX1: begin
        coef_a = COEF1_A;
        coef_b = '0;
      end
      PRED_FIX2: begin
        coef_a = COEF2_A;
        coef_b = COEF2_B;
      end
      PRED_FIX3: begin
        coef_a = COEF3_A;
        coef_b = COEF3_B;
      end
      default: begin
        coef_a = '0;
        coef_b = '0;
      end
    endcase
  end

  assign p1_x    = {{(MAC_W-HIST_W){prev1_i[HIST_W-1]}}, prev1_i};
  assign p2_x    = {{(MAC_W-HIST_W){prev2_i[HIST_W-1]}}, prev2_i};
  assign mac     = (p1_x * coef_a) - (p2_x * coef_b);
  assign mac_rnd = mac + PRED_ROUND;
  assign rnd     = mac_rnd[MAC_W-1:FRAC_W];

  // Clamp to the 22-bit prediction range
  always_comb begin
    if (rnd[RND_W-1:PRED_W-1] == '0 || rnd[RND_W-1:PRED_W-1] == '1) begin
      pred = rnd[PRED_W-1:0];
    end else if (rnd[RND_W-1]) begin
      pred = {1'b1, {(PRED_W-1){1'b0}}};
    end else begin
      pred = {1'b0, {(PRED_W-1){1'b1}}};
    end
  end

  // Nibble times 4096, arithmetic shift, times 64
  assign scaled  = {code_i, {SCALE_W{1'b0}}};
  assign shifted = scaled >>> head_i.shift;
  assign delta   = {shifted, {FRAC_W{1'b0}}};

  assign hist_o = {delta[PRED_W-1], delta} + {pred[PRED_W-1], pred};

  assign smp_wide = hist_o[HIST_W-1:FRAC_W];

  always_comb begin
    if (smp_wide[SMP_W-1:SAMPLE_W-1] == '0 || smp_wide[SMP_W-1:SAMPLE_W-1] == '1) begin
      sample_o = smp_wide[SAMPLE_W-1:0];
    end else if (smp_wide[SMP_W-1]) begin
      sample_o = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sample_o = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

endmodule

@@ rtl/core/stereo_adpcm_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// stereo_adpcm_stream_decoder
// Stereo ADPCM block decoder, one block byte per item.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle unless a pair item must wait for a stalled
// result register. An item is registered on entry and its stereo pair is
// loaded from the entry register into the result register. The rate is set
// by the history feedback: both predictor multiplies, the rounding clamp,
// the history add and the output saturation of each channel sit in the
// combinational logic between the entry register and the history and result
// registers. Header, skipped and clear items produce no result; a stalled
// result register holds only items that would produce a pair.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stereo_adpcm_stream_decoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  sadpcm_in_if.sink     in_i,
  sadpcm_out_if.source  out_o
);
  import sadpcm_pkg::*;

  // Entry register
  logic              s1_valid_q;
  logic              s1_cmd_q;
  logic [BYTE_W-1:0] s1_byte_q;

  // Decoder state
  hist_t            lp1_q, lp2_q, rp1_q, rp2_q;
  head_t            lhead_q, rhead_q;
  logic [POS_W-1:0] pos_q, pos_d;

  // Result register
  logic    out_valid_q;
  sample_t out_left_q, out_right_q;
  logic    out_last_q;

  logic    s1_pair, s1_go, out_load;
  hist_t   lhist, rhist;
  sample_t lsample, rsample;

  assign s1_pair  = (s1_cmd_q == CMD_BYTE) && (pos_q >= POS_START);
  assign s1_go    = s1_valid_q && (!s1_pair || !out_valid_q || out_o.ready);
  assign out_load = s1_go && s1_pair;

  assign in_i.ready = !s1_valid_q || s1_go;

  sadpcm_chan u_left (
    .code_i   (s1_byte_q[CODE_W-1:0]),
    .head_i   (lhead_q),
    .prev1_i  (lp1_q),
    .prev2_i  (lp2_q),
    .hist_o   (lhist),
    .sample_o (lsample)
  );

  sadpcm_chan u_right (
    .code_i   (s1_byte_q[BYTE_W-1:CODE_W]),
    .head_i   (rhead_q),
    .prev1_i  (rp1_q),
    .prev2_i  (rp2_q),
    .hist_o   (rhist),
    .sample_o (rsample)
  );

  always_comb begin
    if (s1_cmd_q == CMD_CLEAR || pos_q >= POS_LAST) begin
      pos_d = '0;
    end else begin
      pos_d = pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_cmd_q  <= in_i.cmd;
      s1_byte_q <= in_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp1_q   <= '0;
      lp2_q   <= '0;
      rp1_q   <= '0;
      rp2_q   <= '0;
      lhead_q <= '0;
      rhead_q <= '0;
      pos_q   <= '0;
    end else if (s1_go) begin
      pos_q <= pos_d;
      if (s1_cmd_q == CMD_CLEAR) begin
        lp1_q <= '0;
        lp2_q <= '0;
        rp1_q <= '0;
        rp2_q <= '0;
      end else if (pos_q == POS_LEFT_HDR) begin
        lhead_q <= s1_byte_q;
      end else if (pos_q == POS_RIGHT_HDR) begin
        rhead_q <= s1_byte_q;
      end else if (s1_pair) begin
        lp2_q <= lp1_q;
        lp1_q <= lhist;
        rp2_q <= rp1_q;
        rp1_q <= rhist;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_left_q  <= lsample;
      out_right_q <= rsample;
      out_last_q  <= (pos_q == POS_LAST);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.left_sample   = out_left_q;
  assign out_o.right_sample  = out_right_q;
  assign out_o.last_in_block = out_last_q;

  // Checks
  `ASSERT_IMP(a_pos_range, clk_i, rst_ni, 1'b1, pos_q <= POS_LAST, "byte position out of range")
  `ASSERT_NXT(a_clear, clk_i, rst_ni, s1_go && (s1_cmd_q == CMD_CLEAR), (pos_q == '0) && (lp1_q == '0) && (lp2_q == '0) && (rp1_q == '0) && (rp2_q == '0), "clear did not zero state")
  `ASSERT_NXT(a_last_flag, clk_i, rst_ni, out_load, out_valid_q && (out_last_q == $past(pos_q == POS_LAST)), "last flag mismatch")
  `ASSERT_NXT(a_hdr_no_result, clk_i, rst_ni, s1_go && !s1_pair && out_valid_q && out_o.ready, !out_valid_q, "result from non-sample item")

endmodule
